// ===== rtl/pcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfr_pkg
// Shared types and constants for the pose command frame receiver.
// ----------------------------------------------------------------------------
package pcfr_pkg;

  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned CHAIN_LEN   = FRAME_LEN - 1;
  localparam int unsigned CHECKED_LEN = 9;
  localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef logic [7:0] byte_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_BAD_END   = 2'd1,
    ST_BAD_CHECK = 2'd2,
    ST_BAD_MODE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_BYTE      = 3'd0,
    CFG_END_BYTE       = 3'd1,
    CFG_MODE_CODE_XY   = 3'd2,
    CFG_MODE_CODE_YAW  = 3'd3,
    CFG_MODE_CODE_BOTH = 3'd4
  } cfg_idx_t;

  localparam byte_t HEAD_RST = 8'd170;
  localparam byte_t END_RST  = 8'd85;
  localparam byte_t XY_RST   = 8'd1;
  localparam byte_t YAW_RST  = 8'd2;
  localparam byte_t BOTH_RST = 8'd3;

  typedef struct packed {
    byte_t head_byte;
    byte_t end_byte;
    byte_t mode_code_xy;
    byte_t mode_code_yaw;
    byte_t mode_code_both;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic signed [15:0] new_yaw;
    logic               write_xy;
    logic               write_yaw;
  } result_t;

endpackage

// ===== rtl/pcfr_if.sv =====
// ----------------------------------------------------------------------------
// pcfr_in_if / pcfr_out_if
// Valid/ready channels for received bytes and decoded frame results.
// ----------------------------------------------------------------------------
interface pcfr_in_if;
  logic              valid;
  logic              ready;
  pcfr_pkg::byte_t   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pcfr_out_if;
  logic                 valid;
  logic                 ready;
  pcfr_pkg::status_t    status;
  logic signed [15:0]   new_x;
  logic signed [15:0]   new_y;
  logic signed [15:0]   new_yaw;
  logic                 write_xy;
  logic                 write_yaw;

  modport source (output valid, output status, output new_x, output new_y,
                  output new_yaw, output write_xy, output write_yaw, input ready);
  modport sink   (input valid, input status, input new_x, input new_y,
                  input new_yaw, input write_xy, input write_yaw, output ready);
endinterface

// ===== rtl/pcfr_cell.sv =====
// ----------------------------------------------------------------------------
// pcfr_cell
// One byte of the frame shift chain; takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
module pcfr_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  pcfr_pkg::byte_t d_in,
  output pcfr_pkg::byte_t d_out
);

  pcfr_pkg::byte_t data_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

// ===== rtl/pcfr_decode.sv =====
// ----------------------------------------------------------------------------
// pcfr_decode
// Checks end and check bytes of a complete frame and decodes the mode.
// ----------------------------------------------------------------------------
module pcfr_decode (
  input  pcfr_pkg::byte_t   chain [pcfr_pkg::CHAIN_LEN],
  input  pcfr_pkg::byte_t   last_byte,
  input  pcfr_pkg::byte_t   check,
  input  pcfr_pkg::cfg_t    cfg,
  output pcfr_pkg::result_t res
);

  // chain[0] holds the newest byte (frame byte 9), chain[9] the head
  pcfr_pkg::byte_t mode;
  logic            wxy;
  logic            wyaw;

  assign mode = chain[8];

  always_comb begin
    res.status = pcfr_pkg::ST_ACCEPTED;
    wxy  = 1'b0;
    wyaw = 1'b0;
    if (last_byte != cfg.end_byte) begin
      res.status = pcfr_pkg::ST_BAD_END;
    end else if (chain[0] != check) begin
      res.status = pcfr_pkg::ST_BAD_CHECK;
    end else if (mode == cfg.mode_code_xy) begin
      wxy = 1'b1;
    end else if (mode == cfg.mode_code_yaw) begin
      wyaw = 1'b1;
    end else if (mode == cfg.mode_code_both) begin
      wxy  = 1'b1;
      wyaw = 1'b1;
    end else begin
      res.status = pcfr_pkg::ST_BAD_MODE;
    end
    res.write_xy  = wxy;
    res.write_yaw = wyaw;
    res.new_x   = wxy  ? $signed({chain[7], chain[6]}) : 16'sd0;
    res.new_y   = wxy  ? $signed({chain[5], chain[4]}) : 16'sd0;
    res.new_yaw = wyaw ? $signed({chain[3], chain[2]}) : 16'sd0;
  end

endmodule

// ===== rtl/pose_command_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// pose_command_frame_receiver_unit
// Hunts for a head byte, collects an eleven-byte pose frame and emits one
// checked and decoded result per frame.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle. Bytes move through a chain of
// ten byte cells; on arrival the eleventh byte is checked as the end byte and
// the chain against the running XOR; the result is registered for next cycle.
// Input is held off only while a finished result sits in that register and the
// sink is not taking it. No clearing pass is needed after reset.
module pose_command_frame_receiver_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  pcfr_in_if.sink                         in_ch,
  pcfr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam pcfr_pkg::count_t LAST_CNT = pcfr_pkg::count_t'(pcfr_pkg::CHAIN_LEN);
  localparam pcfr_pkg::count_t CHK_CNT  = pcfr_pkg::count_t'(pcfr_pkg::CHECKED_LEN);

  pcfr_pkg::cfg_t    cfg_r;
  pcfr_pkg::count_t  count_r, count_nxt;
  pcfr_pkg::byte_t   chk_r, chk_nxt;
  logic              out_valid_r, out_valid_nxt;
  pcfr_pkg::result_t res_r;
  pcfr_pkg::result_t res_dec;
  pcfr_pkg::byte_t   chain [pcfr_pkg::CHAIN_LEN];
  logic              in_xfer;
  logic              store;
  logic              shift_en;
  logic              frame_done;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{head_byte: pcfr_pkg::HEAD_RST, end_byte: pcfr_pkg::END_RST,
                 mode_code_xy: pcfr_pkg::XY_RST, mode_code_yaw: pcfr_pkg::YAW_RST,
                 mode_code_both: pcfr_pkg::BOTH_RST};
    end else if (cfg_we) begin
      case (pcfr_pkg::cfg_idx_t'(cfg_index))
        pcfr_pkg::CFG_HEAD_BYTE:      cfg_r.head_byte      <= cfg_data;
        pcfr_pkg::CFG_END_BYTE:       cfg_r.end_byte       <= cfg_data;
        pcfr_pkg::CFG_MODE_CODE_XY:   cfg_r.mode_code_xy   <= cfg_data;
        pcfr_pkg::CFG_MODE_CODE_YAW:  cfg_r.mode_code_yaw  <= cfg_data;
        pcfr_pkg::CFG_MODE_CODE_BOTH: cfg_r.mode_code_both <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign store       = in_xfer && ((count_r != '0) || (in_ch.rx_byte == cfg_r.head_byte));
  assign frame_done  = store && (count_r == LAST_CNT);
  assign shift_en    = store && !frame_done;

  // shift chain
  for (genvar i = 0; i < pcfr_pkg::CHAIN_LEN; i++) begin : g_chain
    if (i == 0) begin : g_first
      pcfr_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(in_ch.rx_byte),
                        .d_out(chain[i]));
    end else begin : g_next
      pcfr_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(chain[i-1]),
                        .d_out(chain[i]));
    end
  end

  pcfr_decode u_decode (
    .chain     (chain),
    .last_byte (in_ch.rx_byte),
    .check     (chk_r),
    .cfg       (cfg_r),
    .res       (res_dec)
  );

  always_comb begin
    count_nxt     = count_r;
    chk_nxt       = chk_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (frame_done) begin
      count_nxt     = '0;
      chk_nxt       = '0;
      out_valid_nxt = 1'b1;
    end else if (store) begin
      count_nxt = count_r + 1'b1;
      if (count_r < CHK_CNT) begin
        chk_nxt = chk_r ^ in_ch.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      res_r <= res_dec;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = res_r.status;
  assign out_ch.new_x     = res_r.new_x;
  assign out_ch.new_y     = res_r.new_y;
  assign out_ch.new_yaw   = res_r.new_yaw;
  assign out_ch.write_xy  = res_r.write_xy;
  assign out_ch.write_yaw = res_r.write_yaw;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_CNT)
    else $error("frame byte count out of range");

  a_idle_check_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (chk_r == '0))
    else $error("running check not cleared between frames");

  a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> out_valid_r)
    else $error("completed frame gave no result");

  a_accepted_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == pcfr_pkg::ST_ACCEPTED)
      |-> (res_r.write_xy || res_r.write_yaw))
    else $error("accepted frame without write flag");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !frame_done)
    else $error("result overwritten before transfer");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the pose command frame receiver. Serial bytes go in over a
// valid/ready channel with random gaps, decoded frame results come out under
// random back-pressure and are compared field by field against a local frame
// decoder. Directed frames cover every mode, every error status, head bytes
// inside data and overlapping mode codes. Random frames then run under several
// register settings, extremes among them.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHECK_AT = 9;
  localparam int unsigned END_AT   = 10;

  typedef enum int {FLAW_CLEAN, FLAW_END, FLAW_CHECK, FLAW_END_AND_CHECK} flaw_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pcfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcfr_pkg::CFG_DATA_W-1:0] cfg_data;

  pcfr_in_if  in_ch ();
  pcfr_out_if out_ch ();

  pose_command_frame_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder copy of registers and frame state
  pcfr_pkg::cfg_t  regs;
  int unsigned     frame_pos;
  pcfr_pkg::byte_t frame_bytes [pcfr_pkg::FRAME_LEN];
  pcfr_pkg::byte_t check_acc;

  pcfr_pkg::result_t frames_due [$];
  bit                steady;
  int unsigned       fail_count;
  int unsigned       bytes_sent;
  int unsigned       settings_used;
  int unsigned       status_seen [4];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("pose_command_frame_receiver_unit regression: fail");
    $finish;
  end

  function automatic bit absorb_byte(input pcfr_pkg::byte_t b, output pcfr_pkg::result_t r);
    pcfr_pkg::byte_t mode_b;
    r = '0;
    if (frame_pos == 0 && b != regs.head_byte) return 1'b0;
    frame_bytes[frame_pos] = b;
    if (frame_pos < pcfr_pkg::CHECKED_LEN) check_acc ^= b;
    frame_pos++;
    if (frame_pos < pcfr_pkg::FRAME_LEN) return 1'b0;
    mode_b = frame_bytes[1];
    if (frame_bytes[END_AT] != regs.end_byte) begin
      r.status = pcfr_pkg::ST_BAD_END;
    end else if (frame_bytes[CHECK_AT] != check_acc) begin
      r.status = pcfr_pkg::ST_BAD_CHECK;
    end else if (mode_b == regs.mode_code_xy) begin
      r.write_xy = 1'b1;
    end else if (mode_b == regs.mode_code_yaw) begin
      r.write_yaw = 1'b1;
    end else if (mode_b == regs.mode_code_both) begin
      r.write_xy  = 1'b1;
      r.write_yaw = 1'b1;
    end else begin
      r.status = pcfr_pkg::ST_BAD_MODE;
    end
    if (r.write_xy) begin
      r.new_x = {frame_bytes[2], frame_bytes[3]};
      r.new_y = {frame_bytes[4], frame_bytes[5]};
    end
    if (r.write_yaw) r.new_yaw = {frame_bytes[6], frame_bytes[7]};
    frame_pos = 0;
    check_acc = '0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_byte(input pcfr_pkg::byte_t b);
    int unsigned       gap;
    pcfr_pkg::result_t r;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (absorb_byte(b, r)) frames_due.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_frame(input pcfr_pkg::byte_t mode_b, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] yaw,
                            input pcfr_pkg::byte_t spare, input flaw_t flaw);
    pcfr_pkg::byte_t fb [pcfr_pkg::FRAME_LEN];
    fb[0] = regs.head_byte;
    fb[1] = mode_b;
    {fb[2], fb[3]} = x;
    {fb[4], fb[5]} = y;
    {fb[6], fb[7]} = yaw;
    fb[8] = spare;
    fb[CHECK_AT] = '0;
    for (int i = 0; i < pcfr_pkg::CHECKED_LEN; i++) fb[CHECK_AT] ^= fb[i];
    fb[END_AT] = regs.end_byte;
    if (flaw == FLAW_CHECK || flaw == FLAW_END_AND_CHECK)
      fb[CHECK_AT] ^= pcfr_pkg::byte_t'($urandom_range(1, 255));
    if (flaw == FLAW_END || flaw == FLAW_END_AND_CHECK)
      fb[END_AT] ^= pcfr_pkg::byte_t'($urandom_range(1, 255));
    for (int i = 0; i < pcfr_pkg::FRAME_LEN; i++) send_byte(fb[i]);
  endtask

  // completes any half-received frame so the block returns to hunting
  task automatic close_frame();
    while (frame_pos != 0) send_byte(pcfr_pkg::byte_t'($urandom));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input pcfr_pkg::byte_t h, input pcfr_pkg::byte_t e,
                           input pcfr_pkg::byte_t xy, input pcfr_pkg::byte_t yaw,
                           input pcfr_pkg::byte_t both);
    pcfr_pkg::cfg_idx_t order [5];
    pcfr_pkg::byte_t    vals  [5];
    order = '{pcfr_pkg::CFG_HEAD_BYTE, pcfr_pkg::CFG_END_BYTE, pcfr_pkg::CFG_MODE_CODE_XY,
              pcfr_pkg::CFG_MODE_CODE_YAW, pcfr_pkg::CFG_MODE_CODE_BOTH};
    vals  = '{h, e, xy, yaw, both};
    close_frame();
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = '{head_byte: h, end_byte: e, mode_code_xy: xy, mode_code_yaw: yaw,
             mode_code_both: both};
    settings_used++;
    @(posedge clk);
  endtask

  // result checker with random back-pressure
  initial begin
    pcfr_pkg::result_t want;
    int unsigned       stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (frames_due.size() == 0) begin
        $error("result transfer with no frame outstanding (status %0d)", out_ch.status);
        fail_count++;
      end else begin
        want = frames_due.pop_front();
        status_seen[want.status]++;
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.new_x !== want.new_x) begin
          $error("new_x: expected %0d, got %0d", want.new_x, out_ch.new_x);
          fail_count++;
        end
        if (out_ch.new_y !== want.new_y) begin
          $error("new_y: expected %0d, got %0d", want.new_y, out_ch.new_y);
          fail_count++;
        end
        if (out_ch.new_yaw !== want.new_yaw) begin
          $error("new_yaw: expected %0d, got %0d", want.new_yaw, out_ch.new_yaw);
          fail_count++;
        end
        if (out_ch.write_xy !== want.write_xy) begin
          $error("write_xy: expected %0b, got %0b", want.write_xy, out_ch.write_xy);
          fail_count++;
        end
        if (out_ch.write_yaw !== want.write_yaw) begin
          $error("write_yaw: expected %0b, got %0b", want.write_yaw, out_ch.write_yaw);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_frame(regs.mode_code_both, 16'h8000, 16'h7fff, 16'hffff, 8'h00, FLAW_CLEAN);
    send_frame(regs.mode_code_xy, 16'hffff, 16'h0000, 16'h1234, 8'hff, FLAW_CLEAN);
    send_frame(regs.mode_code_yaw, 16'h4321, 16'h8765, 16'h8000, 8'h5a, FLAW_CLEAN);
    send_frame(8'h00, 16'h0102, 16'h0304, 16'h0506, 8'h07, FLAW_CLEAN);
    send_frame(regs.mode_code_both, 16'h1111, 16'h2222, 16'h3333, 8'h44, FLAW_END);
    send_frame(regs.mode_code_both, 16'h1111, 16'h2222, 16'h3333, 8'h44, FLAW_CHECK);
    send_frame(regs.mode_code_xy, 16'h1111, 16'h2222, 16'h3333, 8'h44, FLAW_END_AND_CHECK);
    // head values stored as ordinary data inside a frame
    send_frame(regs.mode_code_both, {2{regs.head_byte}}, {regs.head_byte, 8'h01},
               16'h7fff, regs.head_byte, FLAW_CLEAN);
    settle();
  endtask

  task automatic test_register_extremes();
    load_regs(8'h00, 8'hff, 8'hff, 8'h00, 8'h80);
    send_byte(8'hff);
    send_frame(8'hff, 16'h7fff, 16'h8000, 16'h0001, 8'h00, FLAW_CLEAN);
    send_frame(8'h00, 16'h0000, 16'hffff, 16'h8001, 8'hff, FLAW_CLEAN);
    send_frame(8'h80, 16'haaaa, 16'h5555, 16'hffff, 8'h0f, FLAW_CLEAN);
    send_frame(8'h7f, 16'haaaa, 16'h5555, 16'hffff, 8'h0f, FLAW_CLEAN);
    load_regs(8'hff, 8'h00, 8'h7e, 8'h7e, 8'h7e);
    send_byte(8'h00);
    send_frame(8'h7e, 16'h0f0f, 16'hf0f0, 16'h1357, 8'h33, FLAW_CLEAN);
    load_regs(8'hff, 8'h00, 8'h22, 8'h11, 8'h11);
    send_frame(8'h11, 16'h0f0f, 16'hf0f0, 16'h1357, 8'h33, FLAW_CLEAN);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned     start;
    int unsigned     since_pause;
    pcfr_pkg::byte_t mode_b;
    pcfr_pkg::byte_t noise;
    logic [15:0]     x;
    flaw_t           flaw;
    int unsigned     pick;
    start       = bytes_sent;
    since_pause = 0;
    while (bytes_sent - start < n_bytes) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4)) begin
          noise = pcfr_pkg::byte_t'($urandom);
          if (noise == regs.head_byte && $urandom_range(0, 3) != 0) noise++;
          send_byte(noise);
        end
      end else begin
        case ($urandom_range(0, 5))
          0, 4:    mode_b = regs.mode_code_both;
          1:       mode_b = regs.mode_code_xy;
          2:       mode_b = regs.mode_code_yaw;
          default: mode_b = pcfr_pkg::byte_t'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 75)      flaw = FLAW_CLEAN;
        else if (pick < 85) flaw = FLAW_END;
        else if (pick < 95) flaw = FLAW_CHECK;
        else                flaw = FLAW_END_AND_CHECK;
        x = pick_word();
        if ($urandom_range(0, 7) == 0) x[15:8] = regs.head_byte;
        send_frame(mode_b, x, pick_word(), pick_word(), pcfr_pkg::byte_t'($urandom), flaw);
        since_pause++;
        if (since_pause >= 8 && $urandom_range(0, 2) == 0) begin
          if (frames_due.size() != 0) begin
            in_ch.valid <= 1'b0;
            while (frames_due.size() != 0) @(posedge clk);
          end
          since_pause = 0;
        end
      end
    end
    steady = 1'b0;
    close_frame();
    settle();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    steady        = 1'b0;
    fail_count    = 0;
    bytes_sent    = 0;
    settings_used = 1;
    regs = '{head_byte: pcfr_pkg::HEAD_RST, end_byte: pcfr_pkg::END_RST,
             mode_code_xy: pcfr_pkg::XY_RST, mode_code_yaw: pcfr_pkg::YAW_RST,
             mode_code_both: pcfr_pkg::BOTH_RST};
    frame_pos = 0;
    check_acc = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    load_regs(pcfr_pkg::HEAD_RST, pcfr_pkg::END_RST, pcfr_pkg::XY_RST, pcfr_pkg::YAW_RST,
              pcfr_pkg::BOTH_RST);
    test_random_traffic(80);
    load_regs(pcfr_pkg::byte_t'($urandom), pcfr_pkg::byte_t'($urandom),
              pcfr_pkg::byte_t'($urandom), pcfr_pkg::byte_t'($urandom),
              pcfr_pkg::byte_t'($urandom));
    test_random_traffic(80);
    load_regs(8'h00, 8'h00, 8'h00, 8'hff, 8'hff);
    test_random_traffic(80);
    load_regs(pcfr_pkg::byte_t'($urandom), pcfr_pkg::byte_t'($urandom),
              pcfr_pkg::byte_t'($urandom), pcfr_pkg::byte_t'($urandom),
              pcfr_pkg::byte_t'($urandom));
    test_random_traffic(80);

    settle();
    repeat (10) @(posedge clk);
    $display("run: %0d bytes under %0d register settings", bytes_sent, settings_used);
    $display("frames: %0d accepted, %0d bad end, %0d bad check, %0d unknown mode",
             status_seen[pcfr_pkg::ST_ACCEPTED], status_seen[pcfr_pkg::ST_BAD_END],
             status_seen[pcfr_pkg::ST_BAD_CHECK], status_seen[pcfr_pkg::ST_BAD_MODE]);
    if (fail_count == 0 && frames_due.size() == 0) begin
      $display("pose_command_frame_receiver_unit regression: pass");
    end else begin
      $display("pose_command_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
